/* src/stroke_font_vector_generator_top_defines.svh */
// assertion macros for the stroke font vector generator
`ifndef STROKE_FONT_VECTOR_GENERATOR_TOP_DEFINES_SVH
`define STROKE_FONT_VECTOR_GENERATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SFV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SFV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SFV_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SFV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/sfvg_pkg.sv */
package sfvg_pkg;

  localparam int NumGlyphs = 49;
  localparam int NumSegs = 187;
  localparam logic [5:0] NoGlyph = 6'd49;

  localparam logic [1:0] CfgScale = 2'd0;
  localparam logic [1:0] CfgWidth = 2'd1;
  localparam logic [1:0] CfgColor = 2'd2;

  typedef struct packed {
    logic        has_glyph;
    logic [7:0]  first;
    logic [3:0]  cnt;
    logic [8:0]  adv;
    logic        load;
    logic [15:0] sx;
    logic [15:0] sy;
  } job_t;

  localparam int JobW = $bits(job_t);

  localparam logic [35:0] SEG [NumSegs] = '{
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd230,9'd230},{9'd230,9'd230,9'd26,9'd230},
    {9'd26,9'd230,9'd26,9'd26},
    {9'd128,9'd13,9'd128,9'd243},{9'd77,9'd51,9'd128,9'd13},{9'd77,9'd243,9'd179,9'd243},
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd230,9'd128},{9'd230,9'd128,9'd26,9'd230},
    {9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd230,9'd128},{9'd102,9'd128,9'd230,9'd128},
    {9'd230,9'd128,9'd230,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd26,9'd26,9'd128},{9'd26,9'd128,9'd230,9'd128},{9'd179,9'd26,9'd179,9'd243},
    {9'd26,9'd26,9'd230,9'd26},{9'd26,9'd26,9'd26,9'd128},{9'd26,9'd128,9'd230,9'd128},
    {9'd230,9'd128,9'd230,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd26,9'd230,9'd26},{9'd26,9'd26,9'd26,9'd230},{9'd26,9'd128,9'd230,9'd128},
    {9'd230,9'd128,9'd230,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd77,9'd230},
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd230,9'd230},{9'd230,9'd230,9'd26,9'd230},
    {9'd26,9'd230,9'd26,9'd26},{9'd26,9'd128,9'd230,9'd128},
    {9'd26,9'd26,9'd230,9'd26},{9'd26,9'd26,9'd26,9'd128},{9'd26,9'd128,9'd230,9'd128},
    {9'd230,9'd26,9'd230,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd230,9'd128,9'd26},{9'd128,9'd26,9'd230,9'd230},{9'd64,9'd154,9'd192,9'd154},
    {9'd26,9'd26,9'd26,9'd230},{9'd26,9'd26,9'd192,9'd26},{9'd192,9'd26,9'd230,9'd77},
    {9'd230,9'd77,9'd192,9'd128},{9'd26,9'd128,9'd192,9'd128},{9'd192,9'd128,9'd230,9'd179},
    {9'd230,9'd179,9'd192,9'd230},{9'd192,9'd230,9'd26,9'd230},
    {9'd230,9'd26,9'd26,9'd26},{9'd26,9'd26,9'd26,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd26,9'd26,9'd230},{9'd26,9'd26,9'd179,9'd26},{9'd179,9'd26,9'd230,9'd77},
    {9'd230,9'd77,9'd230,9'd179},{9'd230,9'd179,9'd179,9'd230},{9'd179,9'd230,9'd26,9'd230},
    {9'd26,9'd26,9'd26,9'd230},{9'd26,9'd26,9'd230,9'd26},{9'd26,9'd128,9'd192,9'd128},
    {9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd26,9'd26,9'd230},{9'd26,9'd26,9'd230,9'd26},{9'd26,9'd128,9'd192,9'd128},
    {9'd230,9'd26,9'd26,9'd26},{9'd26,9'd26,9'd26,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd230,9'd230,9'd230,9'd128},{9'd128,9'd128,9'd230,9'd128},
    {9'd26,9'd26,9'd26,9'd230},{9'd230,9'd26,9'd230,9'd230},{9'd26,9'd128,9'd230,9'd128},
    {9'd77,9'd26,9'd179,9'd26},{9'd128,9'd26,9'd128,9'd230},{9'd77,9'd230,9'd179,9'd230},
    {9'd77,9'd26,9'd179,9'd26},{9'd179,9'd26,9'd179,9'd192},{9'd179,9'd192,9'd128,9'd230},
    {9'd128,9'd230,9'd26,9'd230},
    {9'd26,9'd26,9'd26,9'd230},{9'd230,9'd26,9'd26,9'd128},{9'd26,9'd128,9'd230,9'd230},
    {9'd26,9'd26,9'd26,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd26,9'd230,9'd26,9'd26},{9'd26,9'd26,9'd128,9'd141},{9'd128,9'd141,9'd230,9'd26},
    {9'd230,9'd26,9'd230,9'd230},
    {9'd26,9'd230,9'd26,9'd26},{9'd26,9'd26,9'd230,9'd230},{9'd230,9'd230,9'd230,9'd26},
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd230,9'd230},{9'd230,9'd230,9'd26,9'd230},
    {9'd26,9'd230,9'd26,9'd26},
    {9'd26,9'd26,9'd26,9'd230},{9'd26,9'd26,9'd192,9'd26},{9'd192,9'd26,9'd230,9'd77},
    {9'd230,9'd77,9'd192,9'd128},{9'd192,9'd128,9'd26,9'd128},
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd230,9'd230},{9'd230,9'd230,9'd26,9'd230},
    {9'd26,9'd230,9'd26,9'd26},{9'd154,9'd154,9'd243,9'd243},
    {9'd26,9'd26,9'd26,9'd230},{9'd26,9'd26,9'd192,9'd26},{9'd192,9'd26,9'd230,9'd77},
    {9'd230,9'd77,9'd192,9'd128},{9'd192,9'd128,9'd26,9'd128},{9'd128,9'd128,9'd230,9'd230},
    {9'd230,9'd26,9'd26,9'd26},{9'd26,9'd26,9'd26,9'd128},{9'd26,9'd128,9'd230,9'd128},
    {9'd230,9'd128,9'd230,9'd230},{9'd230,9'd230,9'd26,9'd230},
    {9'd26,9'd26,9'd230,9'd26},{9'd128,9'd26,9'd128,9'd230},
    {9'd26,9'd26,9'd26,9'd205},{9'd26,9'd205,9'd128,9'd230},{9'd128,9'd230,9'd230,9'd205},
    {9'd230,9'd205,9'd230,9'd26},
    {9'd26,9'd26,9'd128,9'd230},{9'd128,9'd230,9'd230,9'd26},
    {9'd26,9'd26,9'd64,9'd230},{9'd64,9'd230,9'd128,9'd128},{9'd128,9'd128,9'd192,9'd230},
    {9'd192,9'd230,9'd230,9'd26},
    {9'd26,9'd26,9'd230,9'd230},{9'd230,9'd26,9'd26,9'd230},
    {9'd26,9'd26,9'd128,9'd128},{9'd230,9'd26,9'd128,9'd128},{9'd128,9'd128,9'd128,9'd230},
    {9'd26,9'd26,9'd230,9'd26},{9'd230,9'd26,9'd26,9'd230},{9'd26,9'd230,9'd230,9'd230},
    {9'd102,9'd218,9'd154,9'd218},{9'd154,9'd218,9'd154,9'd243},{9'd154,9'd243,9'd102,9'd243},
    {9'd102,9'd243,9'd102,9'd218},
    {9'd102,9'd210,9'd154,9'd210},{9'd154,9'd210,9'd154,9'd243},{9'd154,9'd243,9'd115,9'd269},
    {9'd115,9'd26,9'd141,9'd26},{9'd141,9'd26,9'd141,9'd56},{9'd141,9'd56,9'd115,9'd72},
    {9'd128,9'd26,9'd128,9'd179},{9'd128,9'd205,9'd128,9'd230},
    {9'd26,9'd51,9'd128,9'd26},{9'd128,9'd26,9'd230,9'd51},{9'd230,9'd51,9'd230,9'd115},
    {9'd230,9'd115,9'd128,9'd154},{9'd128,9'd154,9'd128,9'd184},{9'd128,9'd210,9'd128,9'd236},
    {9'd179,9'd26,9'd102,9'd77},{9'd102,9'd77,9'd102,9'd179},{9'd102,9'd179,9'd179,9'd230},
    {9'd77,9'd26,9'd154,9'd77},{9'd154,9'd77,9'd154,9'd179},{9'd154,9'd179,9'd77,9'd230},
    {9'd102,9'd77,9'd154,9'd77},{9'd154,9'd77,9'd154,9'd102},{9'd154,9'd102,9'd102,9'd102},
    {9'd102,9'd102,9'd102,9'd77},{9'd102,9'd166,9'd154,9'd166},{9'd154,9'd166,9'd154,9'd192},
    {9'd154,9'd192,9'd102,9'd192},{9'd102,9'd192,9'd102,9'd166},
    {9'd51,9'd128,9'd205,9'd128},
    {9'd51,9'd128,9'd205,9'd128},{9'd128,9'd51,9'd128,9'd205},
    {9'd51,9'd230,9'd205,9'd26},
    {9'd51,9'd102,9'd205,9'd102},{9'd51,9'd154,9'd205,9'd154},
    {9'd13,9'd243,9'd243,9'd13},{9'd13,9'd13,9'd77,9'd13},{9'd77,9'd13,9'd77,9'd77},
    {9'd77,9'd77,9'd13,9'd77},{9'd13,9'd77,9'd13,9'd13},{9'd179,9'd179,9'd243,9'd179},
    {9'd243,9'd179,9'd243,9'd243},{9'd243,9'd243,9'd179,9'd243},{9'd179,9'd243,9'd179,9'd179}
  };

  localparam logic [3:0] SEG_CNT [NumGlyphs] = '{
    4'd4,4'd3,4'd4,4'd5,4'd3,4'd5,4'd5,4'd2,4'd5,4'd5,
    4'd3,4'd8,4'd3,4'd6,4'd4,4'd3,4'd5,4'd3,4'd3,4'd4,4'd3,4'd2,4'd4,4'd3,4'd4,4'd5,
    4'd5,4'd6,4'd5,4'd2,4'd4,4'd2,4'd4,4'd2,4'd3,4'd3,
    4'd4,4'd3,4'd3,4'd2,4'd6,4'd3,4'd3,4'd8,4'd1,4'd2,4'd1,4'd2,4'd9
  };

  // index of the first segment of each glyph
  localparam logic [7:0] SEG_FIRST [NumGlyphs] = '{
    8'd0,8'd4,8'd7,8'd11,8'd16,8'd19,8'd24,8'd29,8'd31,8'd36,
    8'd41,8'd44,8'd52,8'd55,8'd61,8'd65,8'd68,8'd73,8'd76,8'd79,8'd83,8'd86,8'd88,8'd92,
    8'd95,8'd99,8'd104,8'd109,8'd115,8'd120,8'd122,8'd126,8'd128,8'd132,8'd134,8'd137,
    8'd140,8'd144,8'd147,8'd150,8'd152,8'd158,8'd161,8'd164,8'd172,8'd173,8'd175,8'd176,
    8'd178
  };

  localparam logic [8:0] ADV [NumGlyphs] = '{
    9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,
    9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd179,9'd256,9'd282,9'd282,
    9'd307,9'd282,9'd282,9'd282,
    9'd282,9'd282,9'd282,9'd282,9'd282,9'd282,9'd333,9'd282,9'd282,9'd282,
    9'd154,9'd154,9'd128,9'd179,9'd282,9'd179,9'd179,9'd179,9'd256,9'd282,9'd256,9'd282,
    9'd282
  };

  function automatic logic [7:0] first_seg(input logic [5:0] g);
    if (g < NoGlyph) return SEG_FIRST[g];
    return '0;
  endfunction

  function automatic logic [5:0] glyph_of(input logic [7:0] c);
    logic [7:0] u;
    logic [5:0] g;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    g = NoGlyph;
    if (u >= 8'h30 && u <= 8'h39) g = 6'(u - 8'h30);
    else if (u >= 8'h41 && u <= 8'h5a) g = 6'(u - 8'h41) + 6'd10;
    else begin
      unique case (u)
        8'h2e: g = 6'd36;
        8'h2c: g = 6'd37;
        8'h27: g = 6'd38;
        8'h21: g = 6'd39;
        8'h3f: g = 6'd40;
        8'h28: g = 6'd41;
        8'h29: g = 6'd42;
        8'h3a: g = 6'd43;
        8'h2d: g = 6'd44;
        8'h2b: g = 6'd45;
        8'h2f: g = 6'd46;
        8'h3d: g = 6'd47;
        8'h25: g = 6'd48;
        default: g = NoGlyph;
      endcase
    end
    return g;
  endfunction

  // rom * scale (q4.8) rounded to a 13-bit integer (q13.0), 9x12 product
  function automatic logic [12:0] scaled(input logic [8:0] r, input logic [11:0] s);
    logic [20:0] p;
    p = 21'(r) * 21'(s) + 21'd128;
    return p[20:8] ;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

/* src/stroke_font_vector_generator_top.sv */
// channel  | handshake              | payload
// in       | in_valid / in_ready    | char_code, start_string, start_x, start_y
// out      | out_valid / out_ready  | record_kind .. last_record
// cfg      | cfg_we (no wait)       | cfg_index, cfg_data
// in the back end, a glyph of n segments takes a calc step and three record beats
// per segment from the glyph rom, plus pen advance and fetch
// a space or unknown code goes through fetch and pen advance and emits nothing
// front end queues up to two items, so input is taken while records stall until it is full
// rst is synchronous; pen resets to 0 and registers to their defaults
module stroke_font_vector_generator_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              start_string,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              record_kind,
  output logic signed [15:0] point_a_x,
  output logic signed [15:0] point_a_y,
  output logic signed [15:0] point_b_x,
  output logic signed [15:0] point_b_y,
  output logic [7:0]        record_width,
  output logic signed [15:0] box_min_x,
  output logic signed [15:0] box_min_y,
  output logic signed [15:0] box_max_x,
  output logic signed [15:0] box_max_y,
  output logic [31:0]       record_color,
  output logic              last_record,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  logic [11:0] glyph_scale;
  logic [7:0]  stroke_width;
  logic [31:0] draw_color;
  logic job_valid, job_ready;
  sfvg_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_scale <= 12'd256;
      stroke_width <= 8'd16;
      draw_color <= 32'hffff_ffff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfvg_pkg::CfgScale: glyph_scale <= cfg_data[11:0];
        sfvg_pkg::CfgWidth: stroke_width <= cfg_data[7:0];
        sfvg_pkg::CfgColor: draw_color <= cfg_data;
        default: ;
      endcase
    end
  end

  sfvg_front u_front (
    .clk, .rst, .in_valid, .in_ready, .char_code, .start_string, .start_x, .start_y,
    .job_valid, .job_ready, .job
  );

  sfvg_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .glyph_scale, .stroke_width, .draw_color,
    .out_valid, .out_ready, .record_kind, .point_a_x, .point_a_y, .point_b_x, .point_b_y,
    .record_width, .box_min_x, .box_min_y, .box_max_x, .box_max_y, .record_color,
    .last_record
  );
endmodule

/* src/sfvg_front.sv */
module sfvg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              start_string,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  output logic              job_valid,
  input  logic              job_ready,
  output sfvg_pkg::job_t    job
);
  logic [5:0] g;
  sfvg_pkg::job_t job_c;

  // two-entry queue toward the back end
  sfvg_pkg::job_t q [2];
  logic       wp, rp;
  logic [1:0] cnt;

  always_comb begin
    g = sfvg_pkg::glyph_of(char_code);
    job_c.has_glyph = (g != sfvg_pkg::NoGlyph);
    job_c.first = job_c.has_glyph ? sfvg_pkg::first_seg(g) : '0;
    job_c.cnt = job_c.has_glyph ? sfvg_pkg::SEG_CNT[g] : '0;
    job_c.adv = job_c.has_glyph ? sfvg_pkg::ADV[g] : 9'd128;
    job_c.load = start_string;
    job_c.sx = start_x;
    job_c.sy = start_y;
  end

  assign in_ready = (cnt != 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (job_valid && job_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(job_valid && job_ready);
    end
    if (in_valid && in_ready) q[wp] <= job_c;
  end

  `include "stroke_font_vector_generator_top_defines.svh"
  `SFV_ASSERT_IMPL(a_no_over, clk, rst, cnt == 2'd2, !in_ready)
  `SFV_ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, cnt != 2'd3)
  `SFV_ASSERT_NEXT(a_fill, clk, rst, in_valid && in_ready && !(job_valid && job_ready),
                   job_valid)
endmodule

/* src/sfvg_back.sv */
module sfvg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  sfvg_pkg::job_t    job,
  input  logic [11:0]       glyph_scale,
  input  logic [7:0]        stroke_width,
  input  logic [31:0]       draw_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              record_kind,
  output logic signed [15:0] point_a_x,
  output logic signed [15:0] point_a_y,
  output logic signed [15:0] point_b_x,
  output logic signed [15:0] point_b_y,
  output logic [7:0]        record_width,
  output logic signed [15:0] box_min_x,
  output logic signed [15:0] box_min_y,
  output logic signed [15:0] box_max_x,
  output logic signed [15:0] box_max_y,
  output logic [31:0]       record_color,
  output logic              last_record
);
  typedef enum logic [1:0] {IDLE, CALC, EMIT, ADVANCE} state_t;
  state_t state;
  logic [1:0] phase;
  logic [7:0] seg_idx;
  logic [3:0] left;
  logic [8:0] adv;
  logic signed [15:0] pen_x, pen_y;
  logic signed [15:0] x0, y0, x1, y1;
  logic signed [15:0] ex, ey;
  logic [35:0] s;
  logic signed [19:0] pad, cap;
  logic signed [15:0] lx, hx, ly, hy;
  logic signed [15:0] px_base, py_base;
  logic signed [19:0] hw;
  logic take_out;

  assign s = sfvg_pkg::SEG[seg_idx];
  assign take_out = !out_valid || out_ready;
  assign job_ready = (state == IDLE);
  assign pad = 20'(stroke_width) + 20'sd24;
  assign cap = 20'(stroke_width) + 20'sd16;
  assign hw = 20'(stroke_width);
  assign lx = (x0 < x1) ? x0 : x1;
  assign hx = (x0 < x1) ? x1 : x0;
  assign ly = (y0 < y1) ? y0 : y1;
  assign hy = (y0 < y1) ? y1 : y0;
  assign ex = (phase == 2'd1) ? x0 : x1;
  assign ey = (phase == 2'd1) ? y0 : y1;
  assign px_base = job.load ? job.sx : pen_x;
  assign py_base = job.load ? job.sy : pen_y;

  // one segment per calc cycle, then three record beats that wait on out_ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      pen_x <= '0;
      pen_y <= '0;
      phase <= '0;
    end else begin
      if (take_out) out_valid <= (state == EMIT);
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            pen_x <= px_base;
            pen_y <= py_base;
            seg_idx <= job.first;
            left <= job.cnt;
            adv <= job.adv;
            state <= job.has_glyph ? CALC : ADVANCE;
          end
        end
        CALC: begin
          x0 <= sfvg_pkg::sat16(20'(pen_x) + 20'(sfvg_pkg::scaled(s[35:27], glyph_scale)));
          y0 <= sfvg_pkg::sat16(20'(pen_y) + 20'(sfvg_pkg::scaled(s[26:18], glyph_scale)));
          x1 <= sfvg_pkg::sat16(20'(pen_x) + 20'(sfvg_pkg::scaled(s[17:9], glyph_scale)));
          y1 <= sfvg_pkg::sat16(20'(pen_y) + 20'(sfvg_pkg::scaled(s[8:0], glyph_scale)));
          phase <= '0;
          state <= EMIT;
        end
        EMIT: begin
          if (take_out) begin
            record_color <= draw_color;
            if (phase == 2'd0) begin
              record_kind <= 1'b0;
              point_a_x <= x0;
              point_a_y <= y0;
              point_b_x <= x1;
              point_b_y <= y1;
              record_width <= stroke_width;
              box_min_x <= sfvg_pkg::sat16(20'(lx) - pad);
              box_min_y <= sfvg_pkg::sat16(20'(ly) - pad);
              box_max_x <= sfvg_pkg::sat16(20'(hx) + pad);
              box_max_y <= sfvg_pkg::sat16(20'(hy) + pad);
              last_record <= 1'b0;
              phase <= 2'd1;
            end else begin
              record_kind <= 1'b1;
              point_a_x <= ex;
              point_a_y <= ey;
              point_b_x <= 16'(hw);
              point_b_y <= 16'(hw);
              record_width <= '0;
              box_min_x <= sfvg_pkg::sat16(20'(ex) - cap);
              box_min_y <= sfvg_pkg::sat16(20'(ey) - cap);
              box_max_x <= sfvg_pkg::sat16(20'(ex) + cap);
              box_max_y <= sfvg_pkg::sat16(20'(ey) + cap);
              if (phase == 2'd1) begin
                last_record <= 1'b0;
                phase <= 2'd2;
              end else begin
                last_record <= (left == 4'd1);
                left <= left - 4'd1;
                seg_idx <= seg_idx + 8'd1;
                state <= (left == 4'd1) ? ADVANCE : CALC;
              end
            end
          end
        end
        ADVANCE: begin
          pen_x <= sfvg_pkg::sat16(20'(pen_x) + 20'(sfvg_pkg::scaled(adv, glyph_scale)));
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `include "stroke_font_vector_generator_top_defines.svh"
  `SFV_ASSERT_IMPL(a_emit_only, clk, rst, $rose(out_valid), $past(state) == EMIT)
  `SFV_ASSERT_IMPL(a_hold, clk, rst, out_valid && !out_ready && state == EMIT, !take_out)
  `SFV_ASSERT_NEXT(a_last_adv, clk, rst,
                   state == EMIT && take_out && phase == 2'd2 && left == 4'd1,
                   state == ADVANCE && last_record)
endmodule

/* tb/tb_stroke_font_vector_generator_top.sv */
module tb_stroke_font_vector_generator_top;

  typedef struct {
    logic        kind;
    logic [15:0] ax, ay, bx, by;
    logic [7:0]  wid;
    logic [15:0] mnx, mny, mxx, mxy;
    logic [31:0] color;
    logic        last;
  } stroke_rec_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] char_code = 0;
  logic start_string = 0;
  logic signed [15:0] start_x = 0, start_y = 0;
  logic out_valid;
  logic out_ready = 0;
  logic record_kind;
  logic [15:0] point_a_x, point_a_y, point_b_x, point_b_y;
  logic [7:0] record_width;
  logic [15:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic [31:0] record_color;
  logic last_record;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  stroke_rec_t pending_recs[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor state
  int pen_x = 0, pen_y = 0;
  int m_scale = 256, m_width = 16;
  logic [31:0] m_color = 32'hffffffff;

  stroke_font_vector_generator_top dut (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #2000000;
    $display("[stroke_font_vector_generator_top] ERROR");
    $finish;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rom_offset(int r);
    return (r * m_scale + 128) >>> 8;
  endfunction

  function automatic int glyph_index(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (u >= "0" && u <= "9") return int'(u - "0");
    if (u >= "A" && u <= "Z") return 10 + int'(u - "A");
    case (u)
      ".": return 36;
      ",": return 37;
      "'": return 38;
      "!": return 39;
      "?": return 40;
      "(": return 41;
      ")": return 42;
      ":": return 43;
      "-": return 44;
      "+": return 45;
      "/": return 46;
      "=": return 47;
      "%": return 48;
      default: return 49;
    endcase
  endfunction

  function automatic stroke_rec_t cap_rec(int cx, int cy);
    stroke_rec_t r;
    r.kind = 1; r.ax = 16'(cx); r.ay = 16'(cy); r.bx = 16'(m_width); r.by = 16'(m_width);
    r.wid = 0;
    r.mnx = 16'(clamp16(cx - m_width - 16)); r.mny = 16'(clamp16(cy - m_width - 16));
    r.mxx = 16'(clamp16(cx + m_width + 16)); r.mxy = 16'(clamp16(cy + m_width + 16));
    r.color = m_color; r.last = 0;
    return r;
  endfunction

  task automatic predict_glyph(logic [7:0] c, logic ld, logic signed [15:0] sx,
                               logic signed [15:0] sy);
    int g, first, adv, x0, y0, x1, y1, pad, cnt;
    logic [35:0] s;
    stroke_rec_t r;
    if (ld) begin
      pen_x = int'(sx); pen_y = int'(sy);
    end
    g = glyph_index(c);
    adv = 128;
    if (g < sfvg_pkg::NumGlyphs) begin
      first = 0;
      for (int i = 0; i < g; i++) first += int'(sfvg_pkg::SEG_CNT[i]);
      cnt = int'(sfvg_pkg::SEG_CNT[g]);
      adv = int'(sfvg_pkg::ADV[g]);
      pad = m_width + 24;
      for (int i = 0; i < cnt; i++) begin
        s = sfvg_pkg::SEG[first + i];
        x0 = clamp16(pen_x + rom_offset(int'(s[35:27])));
        y0 = clamp16(pen_y + rom_offset(int'(s[26:18])));
        x1 = clamp16(pen_x + rom_offset(int'(s[17:9])));
        y1 = clamp16(pen_y + rom_offset(int'(s[8:0])));
        r.kind = 0; r.ax = 16'(x0); r.ay = 16'(y0); r.bx = 16'(x1); r.by = 16'(y1);
        r.wid = 8'(m_width);
        r.mnx = 16'(clamp16((x0 < x1 ? x0 : x1) - pad));
        r.mny = 16'(clamp16((y0 < y1 ? y0 : y1) - pad));
        r.mxx = 16'(clamp16((x0 < x1 ? x1 : x0) + pad));
        r.mxy = 16'(clamp16((y0 < y1 ? y1 : y0) + pad));
        r.color = m_color; r.last = 0;
        pending_recs.push_back(r);
        pending_recs.push_back(cap_rec(x0, y0));
        r = cap_rec(x1, y1);
        r.last = (i == cnt - 1);
        pending_recs.push_back(r);
      end
    end
    pen_x = clamp16(pen_x + rom_offset(adv));
  endtask

  function automatic void cmp_field(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, nm, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    stroke_rec_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_recs.size() == 0) begin
        $display("%0t unexpected record beat: expected none actual kind %0d", $time,
                 record_kind);
        errors++;
      end else begin
        e = pending_recs.pop_front();
        cmp_field("record_kind", e.kind, record_kind);
        cmp_field("point_a_x", e.ax, point_a_x);
        cmp_field("point_a_y", e.ay, point_a_y);
        cmp_field("point_b_x", e.bx, point_b_x);
        cmp_field("point_b_y", e.by, point_b_y);
        cmp_field("record_width", e.wid, record_width);
        cmp_field("box_min_x", e.mnx, box_min_x);
        cmp_field("box_min_y", e.mny, box_min_y);
        cmp_field("box_max_x", e.mxx, box_max_x);
        cmp_field("box_max_y", e.mxy, box_max_y);
        cmp_field("record_color", e.color, record_color);
        cmp_field("last_record", e.last, last_record);
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic ld = 0, logic signed [15:0] sx = 0,
                           logic signed [15:0] sy = 0);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    char_code <= c; start_string <= ld; start_x <= sx; start_y <= sy;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    predict_glyph(c, ld, sx, sy);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      sfvg_pkg::CfgScale: m_scale = int'(val[11:0]);
      sfvg_pkg::CfgWidth: m_width = int'(val[7:0]);
      sfvg_pkg::CfgColor: m_color = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_char();
    string set;
    set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz.,'!?():-+/=% ";
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic test_defaults();
    send_char("A", 1, 16'sd100, 16'sd200);
    send_char("a");
    send_char("%");
    send_char(",");
    send_char(" ");
    send_char(8'd128);
    send_char(8'd255);
    send_char(8'd0);
    send_char("1");
  endtask

  task automatic test_extremes();
    write_reg(sfvg_pkg::CfgScale, 32'hfff);
    write_reg(sfvg_pkg::CfgWidth, 32'hff);
    write_reg(sfvg_pkg::CfgColor, 32'h0);
    send_char("W", 1, 16'sh7fff, 16'sh7fff);
    send_char("%");
    send_char(8'd200);
    send_char("Q", 1, 16'sh8000, 16'sh8000);
    send_char(",");
    send_char("8", 1, 16'sh7f00, 16'sh8000);
    write_reg(sfvg_pkg::CfgScale, 32'h0);
    write_reg(sfvg_pkg::CfgWidth, 32'h0);
    write_reg(sfvg_pkg::CfgColor, 32'hffffffff);
    send_char("M", 1, 16'sh8000, 16'sh7fff);
    send_char(":");
    send_char("?");
    send_char(" ");
  endtask

  task automatic run_random(int n);
    logic ld;
    for (int i = 0; i < n; i++) begin
      ld = ($urandom_range(99) < 20);
      send_char(pick_char(), ld, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random();
    write_reg(sfvg_pkg::CfgScale, 32'd256);
    write_reg(sfvg_pkg::CfgWidth, 32'd16);
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random(50);
    write_reg(sfvg_pkg::CfgScale, $urandom_range(4095));
    write_reg(sfvg_pkg::CfgWidth, $urandom_range(255));
    write_reg(sfvg_pkg::CfgColor, $urandom);
    send_idle_pct = 53; recv_stall_pct = 0;
    run_random(50);
    write_reg(sfvg_pkg::CfgScale, $urandom_range(64, 1024));
    write_reg(sfvg_pkg::CfgWidth, $urandom_range(255));
    write_reg(sfvg_pkg::CfgColor, $urandom);
    send_idle_pct = 0; recv_stall_pct = 53;
    run_random(55);
    write_reg(sfvg_pkg::CfgScale, $urandom_range(4095));
    send_idle_pct = 7; recv_stall_pct = 7;
    run_random(55);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_random();
    in_valid <= 0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_recs.size() == 0)
      $display("[stroke_font_vector_generator_top] OK");
    else
      $display("[stroke_font_vector_generator_top] ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/sfvg_pkg.sv
src/sfvg_front.sv
src/sfvg_back.sv
src/stroke_font_vector_generator_top.sv
tb/tb_stroke_font_vector_generator_top.sv
